[design/cp_tensor_loss_gradient_macros.svh]
// Assertion macros used by the CP loss/gradient back end.
`ifndef CP_TENSOR_LOSS_GRADIENT_MACROS_SVH
`define CP_TENSOR_LOSS_GRADIENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTLG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTLG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ctlg_pkg.sv]
// Shared types and constants for the CP loss/gradient block.
package ctlg_pkg;

    localparam int DEF_MAX_ROWS_FIRST  = 256;
    localparam int DEF_MAX_ROWS_SECOND = 256;
    localparam int DEF_MAX_ROWS_THIRD  = 256;
    localparam int DEF_MAX_RANK        = 16;

    // wide enough for the largest store allowed by the parameter ranges
    localparam int CMD_ADDR_W  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [47:0] G_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] G_MIN = 48'sh8000_0000_0000;
    localparam logic [63:0]        L_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [47:0]        SQ_LIMIT = 48'h0100_0000_0000;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_ENTRY = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_FIRST  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_THIRD  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SEL_I = 2'd0,
        SEL_J = 2'd1,
        SEL_K = 2'd2
    } t_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAMBDA = 1'b0,
        CFG_RANK   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_action                 action;
        logic                    ok;
        logic [CMD_ADDR_W-1:0]   addr;
        logic signed [15:0]      value;
        logic [CMD_ADDR_W-1:0]   base_i;
        logic [CMD_ADDR_W-1:0]   base_j;
        logic [CMD_ADDR_W-1:0]   base_k;
    } t_cmd;

    typedef enum logic [4:0] {
        B_IDLE,
        B_LOAD_SQ,
        B_LOAD_LAM,
        B_LOAD_ADD,
        B_READ_OUT,
        B_FETCH,
        B_FETCH_LAT,
        B_P1_AB,
        B_P1_C,
        B_P1_ACC,
        B_RES,
        B_SQ_A,
        B_SQ_B,
        B_SQ_C,
        B_SQ_D,
        B_LOSS,
        B_P2_F,
        B_P2_M1,
        B_P2_M2,
        B_P2_T,
        B_P2_W
    } t_back_state;

endpackage

[design/ctlg_if.sv]
// Handshake channels: input words, result words and configuration writes.
interface ctlg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [1:0]         factor_mode;
    logic [7:0]         factor_row;
    logic [3:0]         factor_column;
    logic signed [15:0] factor_value;
    logic [7:0]         entry_i;
    logic [7:0]         entry_j;
    logic [7:0]         entry_k;
    logic signed [15:0] entry_value;

    modport source (output valid, action, factor_mode, factor_row, factor_column,
                    factor_value, entry_i, entry_j, entry_k, entry_value,
                    input ready);
    modport sink   (input valid, action, factor_mode, factor_row, factor_column,
                    factor_value, entry_i, entry_j, entry_k, entry_value,
                    output ready);
endinterface

interface ctlg_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] gradient_value;
    logic [63:0]        loss_value;

    modport source (output valid, gradient_value, loss_value, input ready);
    modport sink   (input valid, gradient_value, loss_value, output ready);
endinterface

interface ctlg_cfg_if;
    import ctlg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/ctlg_front.sv]
// Front end: accepts input words, checks indices and forms store addresses.
module ctlg_front #(
    parameter int MAX_ROWS_FIRST  = ctlg_pkg::DEF_MAX_ROWS_FIRST,
    parameter int MAX_ROWS_SECOND = ctlg_pkg::DEF_MAX_ROWS_SECOND,
    parameter int MAX_ROWS_THIRD  = ctlg_pkg::DEF_MAX_ROWS_THIRD,
    parameter int MAX_RANK        = ctlg_pkg::DEF_MAX_RANK
) (
    ctlg_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output ctlg_pkg::t_cmd  o_cmd
);
    import ctlg_pkg::*;

    localparam int OFF_SECOND = MAX_ROWS_FIRST;
    localparam int OFF_THIRD  = MAX_ROWS_FIRST + MAX_ROWS_SECOND;

    t_action               w_action;
    logic                  w_row_ok;
    logic                  w_ok;
    logic                  w_entry_ok;
    logic                  w_keep;
    logic [CMD_ADDR_W-1:0] w_base;

    assign w_action = t_action'(i_in.action);

    always_comb begin
        unique case (i_in.factor_mode)
            MODE_FIRST: begin
                w_row_ok = 32'(i_in.factor_row) < 32'(MAX_ROWS_FIRST);
                w_base   = CMD_ADDR_W'(32'(i_in.factor_row) * 32'(MAX_RANK));
            end
            MODE_SECOND: begin
                w_row_ok = 32'(i_in.factor_row) < 32'(MAX_ROWS_SECOND);
                w_base   = CMD_ADDR_W'((32'(OFF_SECOND) + 32'(i_in.factor_row))
                                       * 32'(MAX_RANK));
            end
            MODE_THIRD: begin
                w_row_ok = 32'(i_in.factor_row) < 32'(MAX_ROWS_THIRD);
                w_base   = CMD_ADDR_W'((32'(OFF_THIRD) + 32'(i_in.factor_row))
                                       * 32'(MAX_RANK));
            end
            default: begin
                w_row_ok = 1'b0;
                w_base   = '0;
            end
        endcase
    end

    assign w_ok       = w_row_ok && (32'(i_in.factor_column) < 32'(MAX_RANK));
    assign w_entry_ok = (32'(i_in.entry_i) < 32'(MAX_ROWS_FIRST))
                     && (32'(i_in.entry_j) < 32'(MAX_ROWS_SECOND))
                     && (32'(i_in.entry_k) < 32'(MAX_ROWS_THIRD));

    always_comb begin
        unique case (w_action)
            ACT_LOAD:  w_keep = w_ok;
            ACT_ENTRY: w_keep = w_entry_ok;
            ACT_READ:  w_keep = 1'b1;
            ACT_CLEAR: w_keep = 1'b1;
            default:   w_keep = 1'b0;
        endcase
    end

    // out-of-range loads and entries are dropped here
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && w_keep;

    always_comb begin
        o_cmd.action = w_action;
        o_cmd.ok     = w_ok;
        o_cmd.addr   = w_base + CMD_ADDR_W'(i_in.factor_column);
        o_cmd.value  = (w_action == ACT_ENTRY) ? i_in.entry_value : i_in.factor_value;
        o_cmd.base_i = CMD_ADDR_W'(32'(i_in.entry_i) * 32'(MAX_RANK));
        o_cmd.base_j = CMD_ADDR_W'((32'(OFF_SECOND) + 32'(i_in.entry_j)) * 32'(MAX_RANK));
        o_cmd.base_k = CMD_ADDR_W'((32'(OFF_THIRD) + 32'(i_in.entry_k)) * 32'(MAX_RANK));
    end

endmodule

[design/ctlg_queue.sv]
// Command queue between the front end and the back end.
module ctlg_queue #(
    parameter int DEPTH = ctlg_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ctlg_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ctlg_pkg::t_cmd  o_cmd
);
    import ctlg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_slot [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rp];

    assign n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

[design/ctlg_back.sv]
// Back end: factor and gradient stores, loss accumulator and update sequencer.
`include "cp_tensor_loss_gradient_macros.svh"
module ctlg_back #(
    parameter int MAX_ROWS_FIRST  = ctlg_pkg::DEF_MAX_ROWS_FIRST,
    parameter int MAX_ROWS_SECOND = ctlg_pkg::DEF_MAX_ROWS_SECOND,
    parameter int MAX_ROWS_THIRD  = ctlg_pkg::DEF_MAX_ROWS_THIRD,
    parameter int MAX_RANK        = ctlg_pkg::DEF_MAX_RANK
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ctlg_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    ctlg_cfg_if.sink        i_cfg,
    ctlg_out_if.source      o_out
);
    import ctlg_pkg::*;

    localparam int DEPTH = (MAX_ROWS_FIRST + MAX_ROWS_SECOND + MAX_ROWS_THIRD) * MAX_RANK;
    localparam int AW    = $clog2(DEPTH);
    localparam int RCW   = $clog2(MAX_RANK + 1);
    localparam int ACC_W = 48 + $clog2(MAX_RANK) + 1;
    localparam logic signed [ACC_W-1:0] ACC_GMAX = ACC_W'(G_MAX);
    localparam logic signed [ACC_W-1:0] ACC_GMIN = ACC_W'(G_MIN);

    t_back_state r_state, n_state;

    logic [15:0]          r_lambda;
    logic [4:0]           r_rank;
    logic [RCW-1:0]       w_rank;

    t_cmd                 r_cmd;
    logic [RCW-1:0]       r_r;
    logic [1:0]           r_sel;
    logic                 r_pass;
    logic signed [15:0]   r_fa, r_fb, r_fc;
    logic signed [31:0]   r_prod;
    logic signed [47:0]   r_prod3;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [47:0]   r_res;
    logic [47:0]          r_mag;
    logic [63:0]          r_sq;
    logic [63:0]          r_p;
    logic signed [31:0]   r_f;
    logic [55:0]          r_p1;
    logic [55:0]          r_p2;
    logic signed [47:0]   r_term;
    logic [63:0]          r_loss;
    logic                 r_out_valid;
    logic signed [47:0]   r_out_grad;
    logic [63:0]          r_out_loss;

    logic [15:0]          r_fmem [DEPTH];
    logic [47:0]          r_gmem [DEPTH];
    logic signed [15:0]   r_fq;
    logic signed [47:0]   r_gq;

    logic                 w_f_we, w_f_re, w_g_we, w_g_re;
    logic [AW-1:0]        w_f_addr, w_g_addr;
    logic [15:0]          w_f_wd;
    logic [47:0]          w_g_wd;

    logic [CMD_ADDR_W-1:0] w_base;
    logic [CMD_ADDR_W-1:0] w_elem_addr;
    logic                 w_last_r;
    logic                 w_out_free;
    logic signed [32:0]   w_lx;
    logic signed [31:0]   w_xx;
    logic [63:0]          w_add;
    logic [64:0]          w_loss_sum;
    logic [63:0]          w_loss_new;
    logic signed [ACC_W-1:0] w_diff;
    logic signed [47:0]   w_res;
    logic signed [15:0]   w_op1, w_op2;
    logic [31:0]          w_mf;
    logic [63:0]          w_m;
    logic                 w_neg;
    logic signed [47:0]   w_tsat;
    logic signed [48:0]   w_gsum;
    logic signed [47:0]   w_gsat;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= '0;
            r_rank   <= 5'd16;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_LAMBDA: r_lambda <= i_cfg.data;
                CFG_RANK:   r_rank   <= i_cfg.data[4:0];
                default:    r_rank   <= r_rank;
            endcase
        end
    end

    assign w_rank = (32'(r_rank) > 32'(MAX_RANK)) ? RCW'(MAX_RANK) : RCW'(r_rank);

    // shared datapath terms
    always_comb begin
        unique case (t_sel'(r_sel))
            SEL_I:   w_base = r_cmd.base_i;
            SEL_J:   w_base = r_cmd.base_j;
            SEL_K:   w_base = r_cmd.base_k;
            default: w_base = r_cmd.base_k;
        endcase
        unique case (t_sel'(r_sel))
            SEL_I: begin
                w_op1 = r_fb;
                w_op2 = r_fc;
            end
            SEL_J: begin
                w_op1 = r_fa;
                w_op2 = r_fc;
            end
            default: begin
                w_op1 = r_fa;
                w_op2 = r_fb;
            end
        endcase
    end

    assign w_elem_addr = w_base + CMD_ADDR_W'(r_r);
    assign w_last_r    = (r_r + 1'b1) == w_rank;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_lx = $signed({1'b0, r_lambda}) * r_cmd.value;
    assign w_xx = r_cmd.value * r_cmd.value;

    assign w_add      = (r_state == B_LOSS) ? ((r_mag >= SQ_LIMIT) ? L_MAX : r_sq) : r_p;
    assign w_loss_sum = {1'b0, r_loss} + {1'b0, w_add};
    assign w_loss_new = w_loss_sum[64] ? L_MAX : w_loss_sum[63:0];

    assign w_diff = r_acc - (ACC_W'(r_cmd.value) <<< 16);
    assign w_res  = (w_diff > ACC_GMAX) ? G_MAX :
                    (w_diff < ACC_GMIN) ? G_MIN : w_diff[47:0];

    assign w_mf  = r_f[31] ? 32'(-r_f) : 32'(r_f);
    assign w_m   = (64'(r_p1) << 9) + (64'(r_p2) >> 15);
    assign w_neg = r_res[47] != r_f[31];
    always_comb begin
        if (w_neg) begin
            w_tsat = (w_m > 64'h0000_8000_0000_0000) ? G_MIN : 48'(-w_m);
        end else begin
            w_tsat = (w_m > 64'h0000_7FFF_FFFF_FFFF) ? G_MAX : 48'(w_m);
        end
    end

    assign w_gsum = 49'(r_gq) + 49'(r_term);
    assign w_gsat = (w_gsum[48] != w_gsum[47]) ? (w_gsum[48] ? G_MIN : G_MAX)
                                               : w_gsum[47:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_f_we   = 1'b0;
        w_f_re   = 1'b0;
        w_g_we   = 1'b0;
        w_g_re   = 1'b0;
        w_f_addr = w_elem_addr[AW-1:0];
        w_g_addr = w_elem_addr[AW-1:0];
        w_f_wd   = i_cmd.value;
        w_g_wd   = w_gsat;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.action)
                        ACT_LOAD: begin
                            o_pop    = 1'b1;
                            w_f_we   = 1'b1;
                            w_f_addr = i_cmd.addr[AW-1:0];
                            n_state  = B_LOAD_SQ;
                        end
                        ACT_ENTRY: begin
                            o_pop   = 1'b1;
                            n_state = (w_rank == '0) ? B_RES : B_FETCH;
                        end
                        ACT_READ: begin
                            if (w_out_free) begin
                                o_pop    = 1'b1;
                                w_g_re   = 1'b1;
                                w_g_addr = i_cmd.addr[AW-1:0];
                                n_state  = B_READ_OUT;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_LOAD_SQ: begin
                w_g_we   = 1'b1;
                w_g_addr = r_cmd.addr[AW-1:0];
                w_g_wd   = 48'(w_lx) << 1;
                n_state  = B_LOAD_LAM;
            end
            B_LOAD_LAM:  n_state = B_LOAD_ADD;
            B_LOAD_ADD:  n_state = B_IDLE;
            B_READ_OUT:  n_state = B_IDLE;
            B_FETCH: begin
                w_f_re  = 1'b1;
                n_state = B_FETCH_LAT;
            end
            B_FETCH_LAT: begin
                if (r_sel == SEL_K) begin
                    n_state = r_pass ? B_P2_F : B_P1_AB;
                end else begin
                    n_state = B_FETCH;
                end
            end
            B_P1_AB:  n_state = B_P1_C;
            B_P1_C:   n_state = B_P1_ACC;
            B_P1_ACC: n_state = w_last_r ? B_RES : B_FETCH;
            B_RES:    n_state = B_SQ_A;
            B_SQ_A:   n_state = B_SQ_B;
            B_SQ_B:   n_state = B_SQ_C;
            B_SQ_C:   n_state = B_SQ_D;
            B_SQ_D:   n_state = B_LOSS;
            B_LOSS:   n_state = (w_rank == '0) ? B_IDLE : B_FETCH;
            B_P2_F: begin
                w_g_re  = 1'b1;
                n_state = B_P2_M1;
            end
            B_P2_M1: n_state = B_P2_M2;
            B_P2_M2: n_state = B_P2_T;
            B_P2_T:  n_state = B_P2_W;
            B_P2_W: begin
                w_g_we = 1'b1;
                if (r_sel == SEL_K) begin
                    n_state = w_last_r ? B_IDLE : B_FETCH;
                end else begin
                    n_state = B_P2_F;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_cmd  <= i_cmd;
                r_acc  <= '0;
                r_r    <= '0;
                r_sel  <= SEL_I;
                r_pass <= 1'b0;
            end
            B_LOAD_SQ:  r_p <= 64'($unsigned(w_xx));
            B_LOAD_LAM: r_p <= 64'(r_p[30:0] * r_lambda);
            B_FETCH_LAT: begin
                unique case (t_sel'(r_sel))
                    SEL_I:   r_fa <= r_fq;
                    SEL_J:   r_fb <= r_fq;
                    default: r_fc <= r_fq;
                endcase
                r_sel <= (r_sel == SEL_K) ? SEL_I : r_sel + 1'b1;
            end
            B_P1_AB:  r_prod  <= r_fa * r_fb;
            B_P1_C:   r_prod3 <= 48'(r_prod * r_fc);
            B_P1_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod3);
                r_r   <= r_r + 1'b1;
            end
            B_RES: begin
                r_res <= w_res;
                r_mag <= w_res[47] ? 48'(-w_res) : w_res;
            end
            B_SQ_A: r_p <= 64'(r_mag[39:20] * r_mag[39:20]);
            B_SQ_B: begin
                r_sq <= r_p << 24;
                r_p  <= 64'(r_mag[39:20] * r_mag[19:0]);
            end
            B_SQ_C: begin
                r_sq <= r_sq + (r_p << 5);
                r_p  <= 64'(r_mag[19:0] * r_mag[19:0]);
            end
            B_SQ_D: r_sq <= r_sq + (r_p >> 16);
            B_LOSS: begin
                r_r    <= '0;
                r_sel  <= SEL_I;
                r_pass <= 1'b1;
            end
            B_P2_F:  r_f  <= w_op1 * w_op2;
            B_P2_M1: r_p1 <= 56'(r_mag[47:24] * w_mf);
            B_P2_M2: r_p2 <= 56'(r_mag[23:0] * w_mf);
            B_P2_T:  r_term <= w_tsat;
            B_P2_W: begin
                if (r_sel == SEL_K) begin
                    r_sel <= SEL_I;
                    r_r   <= r_r + 1'b1;
                end else begin
                    r_sel <= r_sel + 1'b1;
                end
            end
            default: r_sel <= r_sel;
        endcase
    end

    // loss accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == B_IDLE && !i_empty && i_cmd.action == ACT_CLEAR) begin
                r_loss <= '0;
            end else if (r_state == B_LOAD_ADD || r_state == B_LOSS) begin
                r_loss <= w_loss_new;
            end
            if (r_state == B_READ_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_READ_OUT) begin
            r_out_grad <= r_cmd.ok ? r_gq : '0;
            r_out_loss <= r_loss;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.gradient_value = r_out_grad;
    assign o_out.loss_value     = r_out_loss;

    // stores
    always_ff @(posedge i_clk) begin
        if (w_f_we) begin
            r_fmem[w_f_addr] <= w_f_wd;
        end
        if (w_f_re) begin
            r_fq <= r_fmem[w_f_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_g_we) begin
            r_gmem[w_g_addr] <= w_g_wd;
        end
        if (w_g_re) begin
            r_gq <= r_gmem[w_g_addr];
        end
    end

    `CTLG_ASSERT_IMP(a_out_slot_free, i_clk, i_rst_n, r_state == B_READ_OUT, !r_out_valid, "result register still busy")
    `CTLG_ASSERT_IMP(a_pop_only_idle, i_clk, i_rst_n, r_state != B_IDLE, !o_pop, "queue popped while busy")
    `CTLG_ASSERT_IMP(a_rank_bound, i_clk, i_rst_n, r_state == B_P1_ACC || r_state == B_P2_W, r_r < w_rank, "rank counter overrun")
    `CTLG_ASSERT_NXT(a_read_follows, i_clk, i_rst_n, o_pop && i_cmd.action == ACT_READ, r_state == B_READ_OUT, "read did not reach output")

endmodule

[design/cp_tensor_loss_gradient.sv]
// Top level of the CP loss/gradient block: front end, command queue, back end.
// Every load, read and clear passes through the command queue; a read ends in the result register.
// Entries are processed rank component by rank component through the single-port factor and
// gradient stores; one word is processed at a time.
// Reset clears control, configuration (lambda 0, rank 16) and the loss; the stores are not cleared.
module cp_tensor_loss_gradient #(
    parameter int MAX_ROWS_FIRST  = ctlg_pkg::DEF_MAX_ROWS_FIRST,
    parameter int MAX_ROWS_SECOND = ctlg_pkg::DEF_MAX_ROWS_SECOND,
    parameter int MAX_ROWS_THIRD  = ctlg_pkg::DEF_MAX_ROWS_THIRD,
    parameter int MAX_RANK        = ctlg_pkg::DEF_MAX_RANK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctlg_in_if.sink     i_in,
    ctlg_cfg_if.sink    i_cfg,
    ctlg_out_if.source  o_out
);
    import ctlg_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    ctlg_front #(
        .MAX_ROWS_FIRST  (MAX_ROWS_FIRST),
        .MAX_ROWS_SECOND (MAX_ROWS_SECOND),
        .MAX_ROWS_THIRD  (MAX_ROWS_THIRD),
        .MAX_RANK        (MAX_RANK)
    ) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_cmd_in)
    );

    ctlg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    ctlg_back #(
        .MAX_ROWS_FIRST  (MAX_ROWS_FIRST),
        .MAX_ROWS_SECOND (MAX_ROWS_SECOND),
        .MAX_ROWS_THIRD  (MAX_ROWS_THIRD),
        .MAX_RANK        (MAX_RANK)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_cmd_out),
        .o_pop   (w_pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule
